>>> src/psbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbc_pkg
// Shared types and constants of the pendulum swing-up / balance controller.
// ----------------------------------------------------------------------------
package psbc_pkg;

  localparam int unsigned ANGLE_W = 17;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned DRIVE_W = 16;
  localparam int unsigned VEL_W   = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE    = 2'd0,
    MODE_SWING   = 2'd1,
    MODE_BALANCE = 2'd2
  } mode_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_STOP = 2'd0,
    CMD_SET  = 2'd1,
    CMD_HOLD = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWING_THR   = 3'd0,
    REG_BALANCE_THR = 3'd1,
    REG_P_GAIN      = 3'd2,
    REG_D_GAIN      = 3'd3,
    REG_SWING_GAIN  = 3'd4,
    REG_SWING_LIM   = 3'd5,
    REG_BALANCE_LIM = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_VEL,
    OP_VEL_TAKE,
    OP_DIV_IDX,
    OP_IDX_TAKE,
    OP_ROM,
    OP_MUL_A,
    OP_MUL_B,
    OP_MUL_C,
    OP_MUL_D,
    OP_MUL_E,
    OP_SUM,
    OP_RESULT
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEL_START,
    ST_VEL_WAIT,
    ST_IDX_START,
    ST_IDX_WAIT,
    ST_ROM,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_MUL_D,
    ST_MUL_E,
    ST_SUM,
    ST_RESULT
  } state_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic skip_div;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/psbc_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbc_sample_if
// Request channel carrying one angle sample and its timestamp.
// ----------------------------------------------------------------------------
interface psbc_sample_if;
  import psbc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] pend_angle;
  logic        [TIME_W-1:0]  sample_time_ms;
  modport source (output valid, pend_angle, sample_time_ms, input ready);
  modport sink   (input valid, pend_angle, sample_time_ms, output ready);
endinterface

>>> src/psbc_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbc_result_if
// Request channel carrying one motor command result.
// ----------------------------------------------------------------------------
interface psbc_result_if;
  import psbc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic        [MODE_W-1:0]  mode;
  logic        [CMD_W-1:0]   command;
  logic signed [DRIVE_W-1:0] drive;
  logic signed [VEL_W-1:0]   velocity;
  modport source (output valid, mode, command, drive, velocity, input ready);
  modport sink   (input valid, mode, command, drive, velocity, output ready);
endinterface

>>> src/psbc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbc_div
// 32-bit unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psbc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic [31:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dsr_q, dsr_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  always_comb begin
    rem_sh  = {rem_q, quo_q[31]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (!rem_sub[32]) begin
        rem_d = rem_sub[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> src/psbc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbc_datapath
// Sample state, configuration, velocity estimate, cosine ROM, control laws.
// ----------------------------------------------------------------------------
module psbc_datapath import psbc_pkg::*; #(
  parameter int unsigned COS_TABLE_ENTRIES = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic signed [ANGLE_W-1:0]    angle_i,
  input  logic [TIME_W-1:0]            time_i,
  input  dp_cmd_t                      cmd_i,
  output dp_status_t                   status_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [MODE_W-1:0]            out_mode_o,
  output logic [CMD_W-1:0]             out_command_o,
  output logic signed [DRIVE_W-1:0]    out_drive_o,
  output logic signed [VEL_W-1:0]      out_velocity_o
);

  localparam int unsigned AW = $clog2(COS_TABLE_ENTRIES);
  localparam int unsigned JW = $clog2(COS_TABLE_ENTRIES + 1);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  // floor(x / 9000) == (x * IDX_RECIP) >> 40 for every x below 2^26
  localparam longint unsigned IDX_RECIP = ((64'd1 << 40) + 64'd8999) / 64'd9000;

  function automatic longint unsigned rom_entry(input longint unsigned k);
    longint unsigned x, x2, term;
    longint          sum;
    begin
      x    = HALF_PI_Q30 * k / COS_TABLE_ENTRIES;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      term = ((term * x2) >> 30) / 64'd2;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd12;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd30;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd56;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd90;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd132;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd182;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd240;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd306;
      sum  = sum - longint'(term);
      if (sum < 0) sum = 0;
      rom_entry = (longint'(sum) + (64'd1 << 14)) >> 15;
    end
  endfunction

  logic [15:0] cos_rom [COS_TABLE_ENTRIES];
  for (genvar g = 0; g < COS_TABLE_ENTRIES; g++) begin : g_rom
    assign cos_rom[g] = 16'(rom_entry(64'(g)));
  end

  // configuration
  logic [14:0] swing_thr_q, balance_thr_q, swing_lim_q, balance_lim_q;
  logic [15:0] p_gain_q, d_gain_q, swing_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swing_thr_q   <= 15'd3000;
      balance_thr_q <= 15'd1500;
      p_gain_q      <= 16'd38400;
      d_gain_q      <= 16'd2560;
      swing_gain_q  <= 16'd12800;
      swing_lim_q   <= 15'd10000;
      balance_lim_q <= 15'd20000;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SWING_THR:   swing_thr_q   <= cfg_data_i[14:0];
        REG_BALANCE_THR: balance_thr_q <= cfg_data_i[14:0];
        REG_P_GAIN:      p_gain_q      <= cfg_data_i;
        REG_D_GAIN:      d_gain_q      <= cfg_data_i;
        REG_SWING_GAIN:  swing_gain_q  <= cfg_data_i;
        REG_SWING_LIM:   swing_lim_q   <= cfg_data_i[14:0];
        REG_BALANCE_LIM: balance_lim_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // sample front end
  logic signed [ANGLE_W-1:0] prev_ang_q;
  logic [TIME_W-1:0]         prev_time_q;
  logic                      have_prev_q;
  mode_e                     mode_q;

  logic signed [17:0] diff;
  logic signed [27:0] num;
  logic [26:0]        nmag;
  logic [31:0]        dt;
  logic [18:0]        u0;
  logic [15:0]        turn;
  logic [1:0]         quad;
  logic [13:0]        rem;
  logic [16:0]        e17;
  logic signed [15:0] err;
  logic [14:0]        aerr;

  always_comb begin
    diff = 18'(angle_i) - 18'(prev_ang_q);
    num  = 28'(diff) * 28'sd1000;
    nmag = num[27] ? 27'(-num) : 27'(num);
    dt   = time_i - prev_time_q;
    u0   = 19'(angle_i) + 19'd108000;
    if (u0 >= 19'd144000)      turn = 16'(u0 - 19'd144000);
    else if (u0 >= 19'd108000) turn = 16'(u0 - 19'd108000);
    else if (u0 >= 19'd72000)  turn = 16'(u0 - 19'd72000);
    else                       turn = 16'(u0 - 19'd36000);
    if (turn >= 16'd27000) begin
      quad = 2'd3;
      rem  = 14'(turn - 16'd27000);
    end else if (turn >= 16'd18000) begin
      quad = 2'd2;
      rem  = 14'(turn - 16'd18000);
    end else if (turn >= 16'd9000) begin
      quad = 2'd1;
      rem  = 14'(turn - 16'd9000);
    end else begin
      quad = 2'd0;
      rem  = 14'(turn);
    end
    e17  = {1'b0, turn} - 17'd18000;
    err  = $signed(e17[15:0]);
    aerr = err[15] ? 15'(-err) : 15'(err);
  end

  logic [26:0]        nmag_q, vmag_q;
  logic               nneg_q, skip_q;
  logic [31:0]        dt_q;
  logic [1:0]         quad_q;
  logic [13:0]        rem_q;
  logic signed [15:0] err_q;
  logic [14:0]        aerr_q;
  logic signed [31:0] vel_q;
  logic [25:0]        idx_prod_q;
  logic [JW-1:0]      j_q;
  logic [15:0]        cmag_q;
  logic [32:0]        p1_q;
  logic [46:0]        lo_q, hi_q;
  logic signed [32:0] pe_q;
  logic signed [48:0] dv_q;
  logic [37:0]        smag_q;
  logic signed [49:0] bsum_q;

  // table index: remainder scaled by the table size, divided by 9000
  logic [52:0]   idx_mul;
  logic [JW-1:0] idx;

  assign idx_mul = 53'(idx_prod_q) * 53'(IDX_RECIP);
  assign idx     = idx_mul[40 +: JW];

  // velocity divider
  logic        div_start, div_done;
  logic [31:0] div_dividend, div_divisor, quo;

  assign div_start    = (cmd_i.op == OP_DIV_VEL);
  assign div_dividend = 32'(nmag_q);
  assign div_divisor  = dt_q;

  psbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  logic [16:0] c1;
  assign c1 = (quad_q == 2'd0 || quad_q == 2'd3) ? 17'd32768 + 17'(cmag_q)
                                                 : 17'd32768 - 17'(cmag_q);

  // result stage
  logic               bneg;
  logic [49:0]        babs;
  logic [41:0]        bmag;
  logic [14:0]        sclamp, bclamp;
  logic signed [15:0] sdrive, bdrive;
  mode_e              mode_d;
  cmd_e               cmd_d;
  logic signed [15:0] drive_d;

  always_comb begin
    bneg   = bsum_q[49];
    babs   = bneg ? 50'(-bsum_q) : 50'(bsum_q);
    bmag   = babs[49:8];
    sclamp = (smag_q > 38'(swing_lim_q)) ? swing_lim_q : smag_q[14:0];
    bclamp = (bmag > 42'(balance_lim_q)) ? balance_lim_q : bmag[14:0];
    sdrive = vel_q[31] ? -$signed({1'b0, sclamp}) : $signed({1'b0, sclamp});
    bdrive = bneg ? -$signed({1'b0, bclamp}) : $signed({1'b0, bclamp});
    mode_d  = mode_q;
    cmd_d   = CMD_STOP;
    drive_d = '0;
    case (mode_q)
      MODE_SWING: begin
        if (aerr_q < balance_thr_q) begin
          mode_d = MODE_BALANCE;
          cmd_d  = CMD_HOLD;
        end else begin
          cmd_d   = CMD_SET;
          drive_d = sdrive;
        end
      end
      MODE_BALANCE: begin
        if (aerr_q > swing_thr_q) begin
          mode_d = MODE_SWING;
          cmd_d  = CMD_HOLD;
        end else begin
          cmd_d   = CMD_SET;
          drive_d = bdrive;
        end
      end
      default: begin
        mode_d = (aerr_q > swing_thr_q) ? MODE_SWING : MODE_IDLE;
      end
    endcase
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ang_q  <= '0;
      prev_time_q <= '0;
      have_prev_q <= 1'b0;
      mode_q      <= MODE_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_LOAD && (!have_prev_q || dt != '0)) begin
        prev_ang_q  <= angle_i;
        prev_time_q <= time_i;
        have_prev_q <= 1'b1;
      end
      if (cmd_i.op == OP_RESULT) begin
        mode_q      <= mode_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        nmag_q <= nmag;
        nneg_q <= num[27];
        dt_q   <= dt;
        skip_q <= !have_prev_q || dt == '0;
        quad_q <= quad;
        rem_q  <= rem;
        err_q  <= err;
        aerr_q <= aerr;
        vel_q  <= '0;
        vmag_q <= '0;
      end
      OP_VEL_TAKE: begin
        vmag_q <= quo[26:0];
        vel_q  <= nneg_q ? -$signed(quo) : $signed(quo);
      end
      OP_DIV_IDX: idx_prod_q <= 26'(32'(rem_q) * 32'(COS_TABLE_ENTRIES));
      OP_IDX_TAKE: begin
        j_q <= (quad_q == 2'd1 || quad_q == 2'd3)
               ? JW'(COS_TABLE_ENTRIES) - idx : idx;
      end
      OP_ROM:   cmag_q <= (j_q == JW'(COS_TABLE_ENTRIES)) ? 16'd0 : cos_rom[j_q[AW-1:0]];
      OP_MUL_A: p1_q   <= 33'(swing_gain_q) * 33'(c1);
      OP_MUL_B: lo_q   <= 47'(p1_q) * 47'(vmag_q[13:0]);
      OP_MUL_C: hi_q   <= 47'(p1_q) * 47'(vmag_q[26:14]);
      OP_MUL_D: pe_q   <= 33'($signed({1'b0, p_gain_q})) * 33'(err_q);
      OP_MUL_E: dv_q   <= 49'($signed({1'b0, d_gain_q})) * 49'(vel_q);
      OP_SUM: begin
        smag_q <= 38'(((61'(hi_q) << 14) + 61'(lo_q)) >> 23);
        bsum_q <= 50'(pe_q) + 50'(dv_q);
      end
      OP_RESULT: begin
        out_mode_o     <= mode_d;
        out_command_o  <= cmd_d;
        out_drive_o    <= drive_d;
        out_velocity_o <= vel_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.skip_div = skip_q;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

>>> src/psbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbc_ctrl
// Sequencer stepping the datapath through one sample.
// ----------------------------------------------------------------------------
module psbc_ctrl import psbc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_VEL_START;
      ST_VEL_START: state_d = status_i.skip_div ? ST_IDX_START : ST_VEL_WAIT;
      ST_VEL_WAIT:  if (status_i.div_done) state_d = ST_IDX_START;
      ST_IDX_START: state_d = ST_IDX_WAIT;
      ST_IDX_WAIT:  state_d = ST_ROM;
      ST_ROM:       state_d = ST_MUL_A;
      ST_MUL_A:     state_d = ST_MUL_B;
      ST_MUL_B:     state_d = ST_MUL_C;
      ST_MUL_C:     state_d = ST_MUL_D;
      ST_MUL_D:     state_d = ST_MUL_E;
      ST_MUL_E:     state_d = ST_SUM;
      ST_SUM:       state_d = ST_RESULT;
      ST_RESULT:    if (status_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_VEL_START: if (!status_i.skip_div) cmd_o.op = OP_DIV_VEL;
      ST_VEL_WAIT:  if (status_i.div_done) cmd_o.op = OP_VEL_TAKE;
      ST_IDX_START: cmd_o.op = OP_DIV_IDX;
      ST_IDX_WAIT:  cmd_o.op = OP_IDX_TAKE;
      ST_ROM:       cmd_o.op = OP_ROM;
      ST_MUL_A:     cmd_o.op = OP_MUL_A;
      ST_MUL_B:     cmd_o.op = OP_MUL_B;
      ST_MUL_C:     cmd_o.op = OP_MUL_C;
      ST_MUL_D:     cmd_o.op = OP_MUL_D;
      ST_MUL_E:     cmd_o.op = OP_MUL_E;
      ST_SUM:       cmd_o.op = OP_SUM;
      ST_RESULT:    if (status_i.out_free) cmd_o.op = OP_RESULT;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

`ifndef SYNTHESIS
  a_result_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_RESULT |-> status_i.out_free) else $error("result overwrite");
  a_load_to_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_LOAD |=> state_q == ST_VEL_START) else $error("bad load step");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_DIV_VEL |=> !status_i.div_done) else $error("stale divide done");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
`endif

endmodule

>>> src/pendulum_swing_balance_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pendulum_swing_balance_controller
// Swing-up and balance controller: one motor command per angle sample.
// ----------------------------------------------------------------------------
// Each sample steps from accept to ready again as follows: the 32-step
// velocity divide (scaled angle change by elapsed time) dominates,
// followed by the cosine table index (scale, then reciprocal multiply), a
// table read and six multiply/sum steps. On the first sample or when no time
// has elapsed the divide is skipped. A finished result waits in the output
// register while the next sample is accepted; a stalled result holds only
// the final step of the following sample.
module pendulum_swing_balance_controller import psbc_pkg::*; #(
  parameter int unsigned COS_TABLE_ENTRIES = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  psbc_sample_if.sink           sample_i,
  psbc_result_if.source         result_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  psbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  psbc_datapath #(
    .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .angle_i        (sample_i.pend_angle),
    .time_i         (sample_i.sample_time_ms),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .out_ready_i    (result_o.ready),
    .out_valid_o    (result_o.valid),
    .out_mode_o     (result_o.mode),
    .out_command_o  (result_o.command),
    .out_drive_o    (result_o.drive),
    .out_velocity_o (result_o.velocity)
  );

endmodule
